// File: sv/hsvc_pkg.sv
package hsvc_pkg;

  // Hue arithmetic: one turn is 5760 steps, one sector 960 steps.
  localparam logic [16:0] HUE_WRAP   = 17'd34560;  // six turns, lifts any hue above zero
  localparam logic [9:0]  HUE_SECTOR = 10'd960;
  localparam logic [12:0] RECIP_15   = 13'd4370;   // ceil(2^16 / 15)
  localparam logic [5:0]  RECIP_6    = 6'd43;      // ceil(2^8 / 6)
  localparam logic [2:0]  SECTOR_CNT = 3'd6;

  // Saturation and value: 65536 stands for 1.0.
  localparam logic [16:0] UNIT_ONE = 17'd65536;

  // Half-up rounding terms for the three channel forms.
  localparam logic [24:0] ROUND_FULL = 25'h000_8000;         // 2^15
  localparam logic [40:0] ROUND_OFS  = 41'h000_8000_0000;    // 2^31
  localparam logic [47:0] ROUND_MID  = 48'h0020_0000_0000;   // 2^37

  // Hue sectors, 60 degrees each.
  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;
  localparam logic [2:0] SECT_MAG_RED = 3'd5;

  // Hue position handed from the hue unit to the channel datapath.
  typedef struct packed {
    logic [2:0] sector;
    logic [9:0] k;       // weight of the intermediate component, 0..960
  } hsvc_pos_t;

endpackage

// File: sv/hsvc_hue_unit.sv
module hsvc_hue_unit (
  input  logic               clk,
  input  logic [15:0]        hue,
  output hsvc_pkg::hsvc_pos_t pos
);
  import hsvc_pkg::*;

  logic [16:0] u1_r, u1_nxt;
  logic [16:0] u2_r;
  logic [6:0]  t2_r, t2_nxt;
  logic [9:0]  r3_r, r3_nxt;
  logic [2:0]  sec3_r, sec3_nxt;

  logic [23:0] prod15;
  logic [16:0] diff;
  logic [11:0] prod6;
  logic [6:0]  sec_wide;

  // Shift the hue into a positive range without changing it modulo one turn.
  assign u1_nxt = {hue[15], hue} + HUE_WRAP;

  // Count sectors: u / 960 = (u / 64) / 15.
  assign prod15 = 24'(u1_r[16:6] * RECIP_15);
  assign t2_nxt = prod15[22:16];

  // Remainder within the sector and sector index modulo one turn.
  assign diff     = u2_r - 17'(t2_r * HUE_SECTOR);
  assign r3_nxt   = diff[9:0];
  assign prod6    = 12'(t2_r * RECIP_6);
  assign sec_wide = t2_r - 7'(prod6[11:8] * SECTOR_CNT);
  assign sec3_nxt = sec_wide[2:0];

  always_ff @(posedge clk) begin
    u1_r   <= u1_nxt;
    u2_r   <= u1_r;
    t2_r   <= t2_nxt;
    r3_r   <= r3_nxt;
    sec3_r <= sec3_nxt;
  end

  // Rising sectors weight the remainder directly, falling sectors its complement.
  always_comb begin
    pos.sector = sec3_r;
    pos.k      = sec3_r[0] ? (HUE_SECTOR - r3_r) : r3_r;
  end

endmodule

// File: sv/hsv_to_rgba_converter_core.sv
// HSV to packed RGBA color converter, fully pipelined.
//
// Input: drive in_hue (signed, 1/16 degree, any turn), in_saturation and
// in_brightness (signed, 65536 = 1.0, clamped to 0..1) and in_alpha, and
// raise start. A transaction is taken at every rising edge with start high
// and busy low. busy stays low: the pipeline takes one transaction per cycle.
//
// Output: out_color (red 7:0, green 15:8, blue 23:16, alpha 31:24) is shown
// for one cycle with out_valid high. Results leave in the order the
// transactions came in. The receiver cannot stall, so no stage ever holds;
// throughput is one color per clock.
//
// Stages: 1 clamp and hue wrap, 2 V*S product and sector count, 3 sector
// remainder, 4 V*S*k product and offset, 5 channel numerators and the two
// simple bytes, 6 rounding of the intermediate byte and sector packing.
//
// Reset (rst_n low, synchronous) drops every transaction in flight; the
// payload registers keep whatever they hold.
module hsv_to_rgba_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_hue,
  input  logic [17:0] in_saturation,
  input  logic [17:0] in_brightness,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  output logic [31:0] out_color
);
  import hsvc_pkg::*;

  logic [5:0]  vld_r, vld_nxt;

  logic [16:0] s1_s_r, s1_s_nxt;
  logic [16:0] s1_v_r, s1_v_nxt;
  logic [7:0]  s1_a_r;

  logic [32:0] s2_vs_r, s2_vs_nxt;
  logic [16:0] s2_v_r;
  logic [7:0]  s2_a_r;

  logic [32:0] s3_vs_r;
  logic [16:0] s3_v_r;
  logic [7:0]  s3_a_r;

  logic [42:0] s4_xn_r, s4_xn_nxt;
  logic [32:0] s4_mn_r, s4_mn_nxt;
  logic [16:0] s4_v_r;
  logic [2:0]  s4_sec_r;
  logic [7:0]  s4_a_r;

  logic [43:0] s5_nx_r, s5_nx_nxt;
  logic [7:0]  s5_bm_r, s5_bm_nxt;
  logic [7:0]  s5_bc_r, s5_bc_nxt;
  logic [2:0]  s5_sec_r;
  logic [7:0]  s5_a_r;

  logic [31:0] out_color_r, out_color_nxt;

  hsvc_pos_t   pos;
  logic [33:0] vs_full;
  logic [40:0] tm;
  logic [24:0] tc;
  logic [47:0] tx;
  logic [7:0]  bx;
  logic [7:0]  red, green, blue;

  // Clamp a signed unit value to 0..65536.
  function automatic logic [16:0] clamp_unit(input logic [17:0] x);
    logic [16:0] y;
    if (x[17]) begin
      y = '0;
    end else if (x[16:0] > UNIT_ONE || x[16]) begin
      y = UNIT_ONE;
    end else begin
      y = x[16:0];
    end
    return y;
  endfunction

  // The pipeline never holds off a transaction.
  assign busy = 1'b0;

  // Advance the valid bits one stage per cycle alongside the data.
  assign vld_nxt = {vld_r[4:0], start & ~busy};

  // Stage 1: clamp saturation and value; the hue unit wraps the hue.
  assign s1_s_nxt = clamp_unit(in_saturation);
  assign s1_v_nxt = clamp_unit(in_brightness);

  hsvc_hue_unit u_hue (
    .clk (clk),
    .hue (in_hue),
    .pos (pos)
  );

  // Stage 2: chroma product V*S, at most 2^32.
  assign vs_full   = 34'(s1_v_r * s1_s_r);
  assign s2_vs_nxt = vs_full[32:0];

  // Stage 4: intermediate component V*S*k and offset V*(1-S), both over 2^32.
  assign s4_xn_nxt = 43'(s3_vs_r * pos.k);
  assign s4_mn_nxt = {s3_v_r, 16'h0000} - s3_vs_r;

  // Stage 5: the intermediate channel numerator over 2^32*960, plus the
  // bytes of the offset-only and the full-chroma channels.
  assign s5_nx_nxt = {1'b0, s4_xn_r} + {1'b0, s4_mn_r, 10'h000} - {5'h00, s4_mn_r, 6'h00};
  assign tm        = {s4_mn_r, 8'h00} - {8'h00, s4_mn_r} + ROUND_OFS;
  assign s5_bm_nxt = tm[39:32];
  assign tc        = {s4_v_r, 8'h00} - {8'h00, s4_v_r} + ROUND_FULL;
  assign s5_bc_nxt = tc[23:16];

  // Stage 6: N*255/(960*2^32) equals N*17/2^38; round half up.
  assign tx = {s5_nx_r, 4'h0} + {4'h0, s5_nx_r} + ROUND_MID;
  assign bx = tx[45:38];

  always_comb begin
    case (s5_sec_r)
      SECT_RED_YEL: begin
        red = s5_bc_r; green = bx;      blue = s5_bm_r;
      end
      SECT_YEL_GRN: begin
        red = bx;      green = s5_bc_r; blue = s5_bm_r;
      end
      SECT_GRN_CYN: begin
        red = s5_bm_r; green = s5_bc_r; blue = bx;
      end
      SECT_CYN_BLU: begin
        red = s5_bm_r; green = bx;      blue = s5_bc_r;
      end
      SECT_BLU_MAG: begin
        red = bx;      green = s5_bm_r; blue = s5_bc_r;
      end
      SECT_MAG_RED: begin
        red = s5_bc_r; green = s5_bm_r; blue = bx;
      end
      default: begin
        red = s5_bm_r; green = s5_bm_r; blue = s5_bm_r;
      end
    endcase
    out_color_nxt = {s5_a_r, blue, green, red};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_s_r      <= s1_s_nxt;
    s1_v_r      <= s1_v_nxt;
    s1_a_r      <= in_alpha;
    s2_vs_r     <= s2_vs_nxt;
    s2_v_r      <= s1_v_r;
    s2_a_r      <= s1_a_r;
    s3_vs_r     <= s2_vs_r;
    s3_v_r      <= s2_v_r;
    s3_a_r      <= s2_a_r;
    s4_xn_r     <= s4_xn_nxt;
    s4_mn_r     <= s4_mn_nxt;
    s4_v_r      <= s3_v_r;
    s4_sec_r    <= pos.sector;
    s4_a_r      <= s3_a_r;
    s5_nx_r     <= s5_nx_nxt;
    s5_bm_r     <= s5_bm_nxt;
    s5_bc_r     <= s5_bc_nxt;
    s5_sec_r    <= s4_sec_r;
    s5_a_r      <= s4_a_r;
    out_color_r <= out_color_nxt;
  end

  assign out_valid = vld_r[5];
  assign out_color = out_color_r;

  // Every accepted transaction comes out as a result with out_valid high.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("accepted transaction did not produce a result in six cycles");

  // No result appears without a matching earlier transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result strobe without a matching transaction");

  // Alpha travels with its own transaction through all stages.
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color[31:24] == $past(in_alpha, 6)))
    else $error("alpha byte out of step with its transaction");

endmodule
